// File: sv/cau_pkg.sv
package cau_pkg;

    // operand format
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int W2         = 2 * DATA_WIDTH;
    localparam int THR_WIDTH  = 16;

    // operation codes
    localparam logic [2:0] FUNC_ADD = 3'd0;
    localparam logic [2:0] FUNC_SUB = 3'd1;
    localparam logic [2:0] FUNC_MUL = 3'd2;
    localparam logic [2:0] FUNC_DIV = 3'd3;
    localparam logic [2:0] FUNC_MAG = 3'd4;

    // saturation limits
    localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] MIN_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic [2:0]                   func;
        logic signed [DATA_WIDTH-1:0] a_real;
        logic signed [DATA_WIDTH-1:0] a_imag;
        logic signed [DATA_WIDTH-1:0] b_real;
        logic signed [DATA_WIDTH-1:0] b_imag;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] res_real;
        logic signed [DATA_WIDTH-1:0] res_imag;
        logic                         div_zero;
        logic                         overflow;
    } t_out_item;

    // registered products
    typedef struct packed {
        logic [2:0]                   func;
        logic                         dz;
        logic signed [DATA_WIDTH-1:0] a_real;
        logic signed [DATA_WIDTH-1:0] a_imag;
        logic signed [DATA_WIDTH-1:0] b_real;
        logic signed [DATA_WIDTH-1:0] b_imag;
        logic signed [W2-1:0]         p_rr;
        logic signed [W2-1:0]         p_ii;
        logic signed [W2-1:0]         p_ri;
        logic signed [W2-1:0]         p_ir;
        logic signed [W2-1:0]         p_brr;
        logic signed [W2-1:0]         p_bii;
        logic signed [W2-1:0]         p_arr;
        logic signed [W2-1:0]         p_aii;
    } t_prod;

    // one long-division lane
    typedef struct packed {
        logic [W2-1:0]         rem;
        logic [DATA_WIDTH-1:0] lo;
        logic [DATA_WIDTH-1:0] q;
    } t_lane;

    // state carried through the iteration stages
    typedef struct packed {
        logic [2:0]            func;
        logic [DATA_WIDTH-1:0] res_real;
        logic [DATA_WIDTH-1:0] res_imag;
        logic                  dz;
        logic                  ovf;
        logic                  neg_r;
        logic                  neg_i;
        logic                  big_r;
        logic                  big_i;
        t_lane                 lane_r;
        t_lane                 lane_i;
        logic [W2-1:0]         den;
        logic [W2-1:0]         sq_n;
        logic [DATA_WIDTH+2:0] sq_rem;
        logic [DATA_WIDTH-1:0] sq_root;
    } t_iter;

endpackage

// File: sv/cau_mul.sv
module cau_mul import cau_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  t_in_item             i_data,
    input  logic [THR_WIDTH-1:0] i_thr,
    output logic                 o_valid,
    output t_prod                o_data
);

    logic                  r_valid;
    t_prod                 r_data;
    t_prod                 n_data;
    logic [DATA_WIDTH-1:0] abs_br;
    logic [DATA_WIDTH-1:0] abs_bi;

    // divisor magnitudes for the zero test
    assign abs_br = i_data.b_real[DATA_WIDTH-1] ? -i_data.b_real : i_data.b_real;
    assign abs_bi = i_data.b_imag[DATA_WIDTH-1] ? -i_data.b_imag : i_data.b_imag;

    // all products used by multiply, divide and magnitude
    always_comb begin
        n_data        = '0;
        n_data.func   = i_data.func;
        n_data.dz     = (i_data.func == FUNC_DIV) && (abs_br <= DATA_WIDTH'(i_thr))
                        && (abs_bi <= DATA_WIDTH'(i_thr));
        n_data.a_real = i_data.a_real;
        n_data.a_imag = i_data.a_imag;
        n_data.b_real = i_data.b_real;
        n_data.b_imag = i_data.b_imag;
        n_data.p_rr   = W2'(i_data.a_real) * W2'(i_data.b_real);
        n_data.p_ii   = W2'(i_data.a_imag) * W2'(i_data.b_imag);
        n_data.p_ri   = W2'(i_data.a_real) * W2'(i_data.b_imag);
        n_data.p_ir   = W2'(i_data.a_imag) * W2'(i_data.b_real);
        n_data.p_brr  = W2'(i_data.b_real) * W2'(i_data.b_real);
        n_data.p_bii  = W2'(i_data.b_imag) * W2'(i_data.b_imag);
        n_data.p_arr  = W2'(i_data.a_real) * W2'(i_data.a_real);
        n_data.p_aii  = W2'(i_data.a_imag) * W2'(i_data.a_imag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: sv/cau_prep.sv
module cau_prep import cau_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_prod i_data,
    output logic  o_valid,
    output t_iter o_data
);

    logic                     r_valid;
    t_iter                    r_data;
    t_iter                    n_data;
    logic signed [W2:0]       sum_re;
    logic signed [W2:0]       sum_im;
    logic signed [W2:0]       dif_re;
    logic signed [W2:0]       dif_im;
    logic signed [W2:0]       mul_re;
    logic signed [W2:0]       mul_im;
    logic signed [W2:0]       num_re;
    logic signed [W2:0]       num_im;
    logic [W2-1:0]            abs_re;
    logic [W2-1:0]            abs_im;
    logic [W2+FRAC_BITS-1:0]  dvd_re;
    logic [W2+FRAC_BITS-1:0]  dvd_im;
    logic [W2-1:0]            den;
    logic [DATA_WIDTH:0]      f_re;
    logic [DATA_WIDTH:0]      f_im;

    // saturate a wide signed value, overflow flag on top
    function automatic logic [DATA_WIDTH:0] fit(input logic signed [W2:0] x);
        logic ok;
        ok = (&x[W2:DATA_WIDTH-1]) | ~(|x[W2:DATA_WIDTH-1]);
        if (ok) begin
            fit = {1'b0, x[DATA_WIDTH-1:0]};
        end else begin
            fit = {1'b1, x[W2] ? MIN_NEG : MAX_POS};
        end
    endfunction

    // sums, products and division setup
    always_comb begin
        sum_re = (W2+1)'(i_data.a_real) + (W2+1)'(i_data.b_real);
        sum_im = (W2+1)'(i_data.a_imag) + (W2+1)'(i_data.b_imag);
        dif_re = (W2+1)'(i_data.a_real) - (W2+1)'(i_data.b_real);
        dif_im = (W2+1)'(i_data.a_imag) - (W2+1)'(i_data.b_imag);
        mul_re = (W2+1)'(i_data.p_rr) - (W2+1)'(i_data.p_ii);
        mul_im = (W2+1)'(i_data.p_ri) + (W2+1)'(i_data.p_ir);
        mul_re = mul_re >>> FRAC_BITS;
        mul_im = mul_im >>> FRAC_BITS;
        num_re = (W2+1)'(i_data.p_rr) + (W2+1)'(i_data.p_ii);
        num_im = (W2+1)'(i_data.p_ir) - (W2+1)'(i_data.p_ri);
        abs_re = W2'(num_re[W2] ? -num_re : num_re);
        abs_im = W2'(num_im[W2] ? -num_im : num_im);
        dvd_re = {abs_re, {FRAC_BITS{1'b0}}};
        dvd_im = {abs_im, {FRAC_BITS{1'b0}}};
        den    = i_data.p_brr[W2-1:0] + i_data.p_bii[W2-1:0];
    end

    // select per operation
    always_comb begin
        f_re = '0;
        f_im = '0;
        case (i_data.func)
            FUNC_ADD: begin
                f_re = fit(sum_re);
                f_im = fit(sum_im);
            end
            FUNC_SUB: begin
                f_re = fit(dif_re);
                f_im = fit(dif_im);
            end
            FUNC_MUL: begin
                f_re = fit(mul_re);
                f_im = fit(mul_im);
            end
            FUNC_DIV: begin
                f_re = {1'b0, i_data.a_real};
                f_im = {1'b0, i_data.a_imag};
            end
            default: begin
                f_re = '0;
                f_im = '0;
            end
        endcase

        n_data           = '0;
        n_data.func      = i_data.func;
        n_data.dz        = i_data.dz;
        n_data.res_real  = f_re[DATA_WIDTH-1:0];
        n_data.res_imag  = f_im[DATA_WIDTH-1:0];
        n_data.ovf       = f_re[DATA_WIDTH] | f_im[DATA_WIDTH];
        n_data.neg_r     = num_re[W2];
        n_data.neg_i     = num_im[W2];
        n_data.big_r     = W2'(dvd_re[W2+FRAC_BITS-1:DATA_WIDTH]) >= den;
        n_data.big_i     = W2'(dvd_im[W2+FRAC_BITS-1:DATA_WIDTH]) >= den;
        n_data.lane_r.rem = W2'(dvd_re[W2+FRAC_BITS-1:DATA_WIDTH]);
        n_data.lane_r.lo  = dvd_re[DATA_WIDTH-1:0];
        n_data.lane_i.rem = W2'(dvd_im[W2+FRAC_BITS-1:DATA_WIDTH]);
        n_data.lane_i.lo  = dvd_im[DATA_WIDTH-1:0];
        n_data.den       = den;
        n_data.sq_n      = i_data.p_arr[W2-1:0] + i_data.p_aii[W2-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: sv/cau_iter_stage.sv
module cau_iter_stage import cau_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_iter i_data,
    output logic  o_valid,
    output t_iter o_data
);

    logic                  r_valid;
    t_iter                 r_data;
    t_iter                 n_data;
    logic [DATA_WIDTH+2:0] sq_sh;
    logic [DATA_WIDTH+2:0] sq_trial;
    logic                  sq_ge;

    // one quotient bit of a restoring division
    function automatic t_lane lane_step(input t_lane l, input logic [W2-1:0] d);
        logic [W2:0] sh;
        logic        ge;
        t_lane       r;
        sh    = {l.rem, l.lo[DATA_WIDTH-1]};
        ge    = sh >= {1'b0, d};
        r.rem = ge ? W2'(sh - {1'b0, d}) : sh[W2-1:0];
        r.lo  = {l.lo[DATA_WIDTH-2:0], 1'b0};
        r.q   = {l.q[DATA_WIDTH-2:0], ge};
        return r;
    endfunction

    // one quotient bit per lane and one root bit per stage, two radicand bits shifted in
    always_comb begin
        sq_sh    = {i_data.sq_rem[DATA_WIDTH:0], i_data.sq_n[W2-1:W2-2]};
        sq_trial = {1'b0, i_data.sq_root, 2'b01};
        sq_ge    = sq_sh >= sq_trial;

        n_data         = i_data;
        n_data.lane_r  = lane_step(i_data.lane_r, i_data.den);
        n_data.lane_i  = lane_step(i_data.lane_i, i_data.den);
        n_data.sq_n    = {i_data.sq_n[W2-3:0], 2'b00};
        n_data.sq_rem  = sq_ge ? (sq_sh - sq_trial) : sq_sh;
        n_data.sq_root = {i_data.sq_root[DATA_WIDTH-2:0], sq_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: sv/cau_final.sv
module cau_final import cau_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_valid,
    input  t_iter     i_data,
    output logic      o_valid,
    output t_out_item o_data
);

    logic                r_valid;
    t_out_item           r_data;
    t_out_item           n_data;
    logic [DATA_WIDTH:0] q_re;
    logic [DATA_WIDTH:0] q_im;

    // apply sign to a quotient magnitude and saturate
    function automatic logic [DATA_WIDTH:0] sat_q(input logic [DATA_WIDTH-1:0] q,
                                                  input logic neg, input logic big);
        if (neg) begin
            if (big || q > MIN_NEG) begin
                sat_q = {1'b1, MIN_NEG};
            end else begin
                sat_q = {1'b0, -q};
            end
        end else begin
            if (big || q > MAX_POS) begin
                sat_q = {1'b1, MAX_POS};
            end else begin
                sat_q = {1'b0, q};
            end
        end
    endfunction

    // finish divide and magnitude, pass the rest
    always_comb begin
        q_re            = sat_q(i_data.lane_r.q, i_data.neg_r, i_data.big_r);
        q_im            = sat_q(i_data.lane_i.q, i_data.neg_i, i_data.big_i);
        n_data.res_real = i_data.res_real;
        n_data.res_imag = i_data.res_imag;
        n_data.div_zero = i_data.dz;
        n_data.overflow = i_data.ovf;
        case (i_data.func)
            FUNC_DIV: begin
                if (!i_data.dz) begin
                    n_data.res_real = q_re[DATA_WIDTH-1:0];
                    n_data.res_imag = q_im[DATA_WIDTH-1:0];
                    n_data.overflow = q_re[DATA_WIDTH] | q_im[DATA_WIDTH];
                end
            end
            FUNC_MAG: begin
                n_data.res_real = i_data.sq_root[DATA_WIDTH-1] ? MAX_POS : i_data.sq_root;
                n_data.res_imag = '0;
                n_data.overflow = i_data.sq_root[DATA_WIDTH-1];
            end
            default: begin
                n_data.div_zero = i_data.dz;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: sv/complex_arithmetic_unit.sv
// Complex arithmetic unit, signed Q16.16 operands.
// Input channel: i_in_valid / o_in_stall with an operation code and two complex
// operands in i_in_data; a transfer happens on a rising edge with valid high
// and stall low. Output channel: o_out_valid / i_out_stall with the result,
// div_zero and overflow in o_out_data.
// Config channel: i_cfg_valid / o_cfg_ready writes the 16-bit zero threshold
// for the divisor test; ready is always high. Write it only while idle.
// The path has DATA_WIDTH + 4 register stages: input register, product stage,
// combine stage, one stage per quotient and root bit (the restoring divider
// and the square root run side by side), and the output register. One item
// per cycle while the output is not held; every operation takes the same path.
// When the receiver stalls a held result, the whole pipeline freezes and
// o_in_stall rises in the same cycle; nothing is lost or repeated.
// Reset (synchronous, active low) clears every valid bit and sets the
// threshold to zero.
module complex_arithmetic_unit import cau_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [THR_WIDTH-1:0] i_cfg_data
);

    logic                 en;
    logic                 r_in_valid;
    t_in_item             r_in_data;
    logic [THR_WIDTH-1:0] r_thr;
    logic                 prod_valid;
    t_prod                prod_data;
    logic                 it_valid [DATA_WIDTH+1];
    t_iter                it_data  [DATA_WIDTH+1];

    // pipeline moves unless the output is held
    assign en          = ~(o_out_valid & i_out_stall);
    assign o_in_stall  = ~en;
    assign o_cfg_ready = 1'b1;

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (en) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in_data <= i_in_data;
        end
    end

    cau_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_in_valid),
        .i_data  (r_in_data),
        .i_thr   (r_thr),
        .o_valid (prod_valid),
        .o_data  (prod_data)
    );

    cau_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (prod_valid),
        .i_data  (prod_data),
        .o_valid (it_valid[0]),
        .o_data  (it_data[0])
    );

    // one stage per quotient and root bit
    for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_iter
        cau_iter_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (it_valid[k]),
            .i_data  (it_data[k]),
            .o_valid (it_valid[k+1]),
            .o_data  (it_data[k+1])
        );
    end

    cau_final u_final (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (it_valid[DATA_WIDTH]),
        .i_data  (it_data[DATA_WIDTH]),
        .o_valid (o_out_valid),
        .o_data  (o_out_data)
    );

endmodule

// File: sv/cau_checker.sv
module cau_checker import cau_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input t_out_item            o_out_data
);

    // a held result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("held result changed");

    // input only stalls behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a held result");

    // a zero-divisor result never saturates
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.div_zero |-> !o_out_data.overflow)
        else $error("div_zero and overflow together");

    // reset empties the output
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (.*);

// File: sim/testbench.sv
module testbench;
    import cau_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RANDOM_ITEMS   = 130;

    // result predictor and store of expected results
    class alu_scoreboard;
        t_out_item       pending[$];
        logic [15:0]     threshold;
        int              errors;

        function new();
            threshold = '0;
            errors    = 0;
        endfunction

        // clamp a wide value to the signed result range
        function logic [DATA_WIDTH-1:0] clamp(input logic signed [129:0] v, inout logic ovf);
            logic signed [129:0] hi;
            logic signed [129:0] lo;
            hi = 130'(MAX_POS);
            lo = 130'($signed(MIN_NEG));
            if (v > hi) begin
                ovf = 1'b1;
                return MAX_POS;
            end
            if (v < lo) begin
                ovf = 1'b1;
                return MIN_NEG;
            end
            return v[DATA_WIDTH-1:0];
        endfunction

        // signed quotient of num * 2^FRAC_BITS / den, truncated toward zero
        function logic [DATA_WIDTH-1:0] quotient(input logic signed [129:0] num,
                                                 input logic [129:0] den, inout logic ovf);
            logic [129:0] m;
            logic [129:0] q;
            logic [129:0] lim;
            m = (num < 0) ? -num : num;
            q = (m << FRAC_BITS) / den;
            lim = 130'(MAX_POS);
            if (num < 0) begin
                if (q > lim + 1) begin
                    ovf = 1'b1;
                    return MIN_NEG;
                end
                return DATA_WIDTH'(-q);
            end
            if (q > lim) begin
                ovf = 1'b1;
                return MAX_POS;
            end
            return q[DATA_WIDTH-1:0];
        endfunction

        function t_out_item compute(input t_in_item it);
            t_out_item r;
            logic signed [129:0] ar, ai, br, bi, mbr, mbi;
            logic [129:0] den, s, c, root_v, lim;
            logic ovf;
            ar = 130'(it.a_real);
            ai = 130'(it.a_imag);
            br = 130'(it.b_real);
            bi = 130'(it.b_imag);
            r = '0;
            ovf = 1'b0;
            case (it.func)
                FUNC_ADD: begin
                    r.res_real = clamp(ar + br, ovf);
                    r.res_imag = clamp(ai + bi, ovf);
                end
                FUNC_SUB: begin
                    r.res_real = clamp(ar - br, ovf);
                    r.res_imag = clamp(ai - bi, ovf);
                end
                FUNC_MUL: begin
                    r.res_real = clamp((ar * br - ai * bi) >>> FRAC_BITS, ovf);
                    r.res_imag = clamp((ar * bi + ai * br) >>> FRAC_BITS, ovf);
                end
                FUNC_DIV: begin
                    mbr = (br < 0) ? -br : br;
                    mbi = (bi < 0) ? -bi : bi;
                    if (mbr <= 130'(threshold) && mbi <= 130'(threshold)) begin
                        r.res_real = it.a_real;
                        r.res_imag = it.a_imag;
                        r.div_zero = 1'b1;
                    end else begin
                        den = br * br + bi * bi;
                        r.res_real = quotient(ar * br + ai * bi, den, ovf);
                        r.res_imag = quotient(ai * br - ar * bi, den, ovf);
                    end
                end
                FUNC_MAG: begin
                    s = ar * ar + ai * ai;
                    root_v = '0;
                    for (int b = 63; b >= 0; b--) begin
                        c = root_v | (130'd1 << b);
                        if (c * c <= s) root_v = c;
                    end
                    lim = 130'(MAX_POS);
                    if (root_v > lim) begin
                        root_v = lim;
                        ovf = 1'b1;
                    end
                    r.res_real = root_v[DATA_WIDTH-1:0];
                end
                default: ;
            endcase
            r.overflow = ovf;
            return r;
        endfunction

        function void note_input(input t_in_item it);
            pending.push_back(compute(it));
        endfunction

        function void check_result(input t_out_item got);
            t_out_item exp_r;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", got);
                return;
            end
            exp_r = pending.pop_front();
            if (got.res_real !== exp_r.res_real || got.res_imag !== exp_r.res_imag ||
                got.div_zero !== exp_r.div_zero || got.overflow !== exp_r.overflow) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: expected re=%h im=%h dz=%b ov=%b, ",
                              "got re=%h im=%h dz=%b ov=%b"},
                             exp_r.res_real, exp_r.res_imag, exp_r.div_zero, exp_r.overflow,
                             got.res_real, got.res_imag, got.div_zero, got.overflow);
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in_item             i_in_data;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_out_item            o_out_data;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [THR_WIDTH-1:0] i_cfg_data;

    alu_scoreboard sb;
    int            send_idle_pct;
    int            recv_stall_pct;
    int            hold_cycles;

    complex_arithmetic_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver stalls, with an optional long hold-off
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                i_out_stall = 1'b1;
                hold_cycles--;
            end else begin
                i_out_stall = ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_data);
    end

    // watchdog on cycles without any transfer
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) quiet = 0;
            else quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("complex_arithmetic_unit regression: fail");
                $finish;
            end
        end
    end

    // send one operand transfer
    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_input(it);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // threshold write while idle
    task automatic write_threshold(input logic [15:0] thr);
        drain();
        i_cfg_valid = 1'b1;
        i_cfg_data  = thr;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.threshold = thr;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [31:0] rand_operand();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0, 1: v = $urandom;
            2:    v = $urandom_range(0, 8 << 16);
            3:    v = -$urandom_range(0, 8 << 16);
            4:    v = $urandom_range(0, 70000) * ($urandom_range(0, 1) ? 1 : -1);
            default: begin
                case ($urandom_range(0, 4))
                    0: v = MAX_POS;
                    1: v = MIN_NEG;
                    2: v = 0;
                    3: v = 1;
                    default: v = '1;
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic t_in_item make_item(input logic [2:0] f, input logic [31:0] ar,
                                           input logic [31:0] ai, input logic [31:0] br,
                                           input logic [31:0] bi);
        t_in_item it;
        it.func   = f;
        it.a_real = ar;
        it.a_imag = ai;
        it.b_real = br;
        it.b_imag = bi;
        return it;
    endfunction

    task automatic send_random(input int n);
        t_in_item it;
        for (int k = 0; k < n; k++) begin
            it = make_item(($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                                        : 3'($urandom_range(0, 4)),
                           rand_operand(), rand_operand(), rand_operand(), rand_operand());
            send_item(it);
        end
    endtask

    initial begin
        logic [15:0] thr_list [4];
        sb = new();
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed corners at the reset threshold
        send_item(make_item(FUNC_ADD, MAX_POS, MIN_NEG, MAX_POS, MIN_NEG));
        send_item(make_item(FUNC_ADD, 32'h0001_8000, '1, 32'hFFFF_0000, 1));
        send_item(make_item(FUNC_SUB, MIN_NEG, MAX_POS, MAX_POS, MIN_NEG));
        send_item(make_item(FUNC_SUB, 0, 0, 0, 0));
        send_item(make_item(FUNC_MUL, MAX_POS, MAX_POS, MAX_POS, MAX_POS));
        send_item(make_item(FUNC_MUL, MIN_NEG, MIN_NEG, MIN_NEG, MIN_NEG));
        send_item(make_item(FUNC_MUL, 32'h0002_0000, 32'h0003_0000, '1, 32'h0000_8000));
        send_item(make_item(FUNC_DIV, 32'h0005_0000, 32'hFFFD_0000, 0, 0));
        send_item(make_item(FUNC_DIV, MIN_NEG, MAX_POS, 1, 0));
        send_item(make_item(FUNC_DIV, 32'h0001_0000, 0, 32'h0003_0000, 0));
        send_item(make_item(FUNC_DIV, 32'h0007_0000, '1, 32'hFFFE_0000, 32'h0001_0000));
        send_item(make_item(FUNC_DIV, MIN_NEG, 0, '1, 0));
        send_item(make_item(FUNC_DIV, 1, 1, MIN_NEG, MIN_NEG));
        send_item(make_item(FUNC_MAG, MIN_NEG, MIN_NEG, MAX_POS, 1));
        send_item(make_item(FUNC_MAG, 32'h0003_0000, 32'hFFFC_0000, 0, 0));
        send_item(make_item(FUNC_MAG, 0, 0, '1, '1));
        send_item(make_item(3'd5, MAX_POS, MAX_POS, MAX_POS, MAX_POS));
        send_item(make_item(3'd6, '1, '1, '1, '1));
        send_item(make_item(3'd7, MIN_NEG, 1, 1, MIN_NEG));

        thr_list[0] = 16'd0;
        thr_list[1] = 16'hFFFF;
        thr_list[2] = 16'($urandom);
        thr_list[3] = 16'd1;
        for (int p = 0; p < 4; p++) begin
            write_threshold(thr_list[p]);
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            if (p == 0) begin
                // fill the pipeline against a long receiver hold-off
                hold_cycles = 300;
                send_random(60);
            end
            if (p == 1) begin
                // divide edge cases against the full threshold
                send_item(make_item(FUNC_DIV, 3, 4, 32'h0000_FFFF, 32'hFFFF_0001));
                send_item(make_item(FUNC_DIV, 3, 4, 32'h0001_0000, 0));
            end
            send_random(RANDOM_ITEMS);
        end

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("complex_arithmetic_unit regression: pass");
        else
            $display("complex_arithmetic_unit regression: fail");
        $finish;
    end
endmodule
